[rtl/assert_macros.svh]
// Assertion macros for the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property under an asynchronous active-low reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Plain condition that holds at every clock edge out of reset.
`define ASSERT_HOLD(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

[rtl/frsb_pkg.sv]
// Package for the feathered RGBA seam blend: widths, register codes, stage structs.
// No dependencies; used by the interfaces, the divider step and the top level.
package frsb_pkg;

	localparam int MAX_SPAN  = 4096;
	localparam int SPAN_W    = 12;
	localparam int PIX_W     = 32;
	localparam int CH_N      = 4;
	localparam int CH_W      = 8;
	localparam int WD_W      = SPAN_W + 1;
	localparam int N_W       = SPAN_W + 3;
	localparam int PROD_W    = CH_W + WD_W;
	localparam int REM_W     = WD_W + CH_W + 1;
	localparam int DVS_W     = REM_W - 1;
	localparam int CFG_W     = 32;
	localparam int ADDR_W    = 4;
	localparam int REG_IDX_W = 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_H_OVERLAP = 2'd0,
		REG_H_FEATHER = 2'd1,
		REG_V_OVERLAP = 2'd2,
		REG_V_FEATHER = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic             mix;
		logic [PIX_W-1:0] byp;
	} ctl_t;

	typedef struct packed {
		logic [CH_N-1:0][REM_W-1:0] rem;
		logic [CH_N-1:0][CH_W-1:0]  quo;
		logic [DVS_W-1:0]           dvs;
		ctl_t                       ctl;
	} div_t;

	function automatic logic [SPAN_W-1:0] span_clamp(logic [SPAN_W-1:0] v);
		if (int'(v) > MAX_SPAN - 1)
			return SPAN_W'(MAX_SPAN - 1);
		return v;
	endfunction

endpackage

[rtl/frsb_if.sv]
// Valid/ready stream interfaces for the pixel input and blended output beats.
// Depends on frsb_pkg for field widths.
interface frsb_in_if;
	logic                         valid;
	logic                         ready;
	logic                         axis;
	logic                         blend_enable;
	logic [frsb_pkg::SPAN_W-1:0]  position;
	logic [frsb_pkg::PIX_W-1:0]   dest_pixel;
	logic [frsb_pkg::PIX_W-1:0]   source_pixel;

	modport source (output valid, axis, blend_enable, position, dest_pixel, source_pixel,
		input ready);
	modport sink (input valid, axis, blend_enable, position, dest_pixel, source_pixel,
		output ready);
endinterface

interface frsb_out_if;
	logic                       valid;
	logic                       ready;
	logic [frsb_pkg::PIX_W-1:0] blended_pixel;

	modport source (output valid, blended_pixel, input ready);
	modport sink (input valid, blended_pixel, output ready);
endinterface

[rtl/frsb_div_step.sv]
// One restoring division step for all four channels, with its own stage register.
// Depends on frsb_pkg for div_t and widths.
module frsb_div_step (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  frsb_pkg::div_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output frsb_pkg::div_t out_data
);

	frsb_pkg::div_t nxt;
	frsb_pkg::div_t step_q;
	logic           vld_q;

	always_comb begin
		nxt = in_data;
		for (int c = 0; c < frsb_pkg::CH_N; c++) begin
			if (in_data.rem[c] >= {1'b0, in_data.dvs}) begin
				nxt.rem[c] = in_data.rem[c] - {1'b0, in_data.dvs};
				nxt.quo[c] = {in_data.quo[c][frsb_pkg::CH_W-2:0], 1'b1};
			end else begin
				nxt.quo[c] = {in_data.quo[c][frsb_pkg::CH_W-2:0], 1'b0};
			end
		end
		nxt.dvs = in_data.dvs >> 1;
	end

	assign in_ready  = !vld_q || out_ready;
	assign out_valid = vld_q;
	assign out_data  = step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			step_q <= nxt;
		end
	end

endmodule

[rtl/feathered_rgba_seam_blend.sv]
// Feathered RGBA8 seam blend: weight stage, product stage, 8-step divider, output register.
// Depends on frsb_pkg, frsb_if.sv and frsb_div_step.
//
//  channel  | dir | beat contents
//  ---------+-----+----------------------------------------------------------
//  pix_in   | in  | axis, blend_enable, position, dest_pixel, source_pixel
//  pix_out  | out | blended_pixel
//  apb      | in  | register write/read, four 12-bit overlap/feather registers
//
// One pixel per cycle sustained while pix_out accepts; each result passes every stage register in order.
// Depth is set by the per-channel rounded division by 2F, one quotient bit per stage.
// Reset clears the stage valid bits and the four registers.
// A stall holds each stage; empty stages keep filling, so bubbles close up.
module feathered_rgba_seam_blend (
	input  logic                          clk,
	input  logic                          arst_n,
	frsb_in_if.sink                       pix_in,
	frsb_out_if.source                    pix_out,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [frsb_pkg::ADDR_W-1:0]   paddr,
	input  logic [frsb_pkg::CFG_W-1:0]    pwdata,
	output logic [frsb_pkg::CFG_W-1:0]    prdata,
	output logic                          pready
);

	localparam int SW = frsb_pkg::SPAN_W;
	localparam int CN = frsb_pkg::CH_N;
	localparam int CW = frsb_pkg::CH_W;

	logic [SW-1:0] h_ov_q, h_fe_q, v_ov_q, v_fe_q;
	logic          wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_ov_q <= '0;
			h_fe_q <= '0;
			v_ov_q <= '0;
			v_fe_q <= '0;
		end else if (wr) begin
			unique case (frsb_pkg::reg_idx_t'(paddr[3:2]))
				frsb_pkg::REG_H_OVERLAP: h_ov_q <= pwdata[SW-1:0];
				frsb_pkg::REG_H_FEATHER: h_fe_q <= pwdata[SW-1:0];
				frsb_pkg::REG_V_OVERLAP: v_ov_q <= pwdata[SW-1:0];
				frsb_pkg::REG_V_FEATHER: v_fe_q <= pwdata[SW-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (frsb_pkg::reg_idx_t'(paddr[3:2]))
			frsb_pkg::REG_H_OVERLAP: prdata = frsb_pkg::CFG_W'(h_ov_q);
			frsb_pkg::REG_H_FEATHER: prdata = frsb_pkg::CFG_W'(h_fe_q);
			frsb_pkg::REG_V_OVERLAP: prdata = frsb_pkg::CFG_W'(v_ov_q);
			frsb_pkg::REG_V_FEATHER: prdata = frsb_pkg::CFG_W'(v_fe_q);
		endcase
	end

	// Stage 1: weight n/(2F) and pass/mix decision
	logic [SW-1:0]                    pos_c, ov_c, fe_c;
	logic signed [frsb_pkg::N_W-1:0]  n_c;
	logic [frsb_pkg::WD_W-1:0]        wn_c, wd_c;
	frsb_pkg::ctl_t                   ctl_c;
	logic [CW-1:0]                    src_a, dst_a;

	always_comb begin
		pos_c = frsb_pkg::span_clamp(pix_in.position);
		ov_c  = frsb_pkg::span_clamp(pix_in.axis ? v_ov_q : h_ov_q);
		fe_c  = frsb_pkg::span_clamp(pix_in.axis ? v_fe_q : h_fe_q);
		n_c   = $signed({2'b0, pos_c, 1'b0}) - $signed({3'b0, ov_c}) + $signed({3'b0, fe_c});
		if (!pix_in.blend_enable) begin
			wn_c = frsb_pkg::WD_W'(1);
			wd_c = frsb_pkg::WD_W'(1);
		end else if (fe_c == '0) begin
			wd_c = frsb_pkg::WD_W'(1);
			wn_c = ({pos_c, 1'b0} < {1'b0, ov_c}) ? '0 : frsb_pkg::WD_W'(1);
		end else begin
			wd_c = {fe_c, 1'b0};
			priority if (n_c <= 0)
				wn_c = '0;
			else if (n_c >= $signed({2'b0, wd_c}))
				wn_c = wd_c;
			else
				wn_c = n_c[frsb_pkg::WD_W-1:0];
		end
		src_a = pix_in.source_pixel[frsb_pkg::PIX_W-1 -: CW];
		dst_a = pix_in.dest_pixel[frsb_pkg::PIX_W-1 -: CW];
		ctl_c.mix = 1'b0;
		priority if (src_a == '0)
			ctl_c.byp = pix_in.dest_pixel;
		else if (dst_a == '0 || wn_c == wd_c)
			ctl_c.byp = pix_in.source_pixel;
		else if (wn_c == '0)
			ctl_c.byp = pix_in.dest_pixel;
		else begin
			ctl_c.byp = pix_in.dest_pixel;
			ctl_c.mix = 1'b1;
		end
	end

	logic                        v_s1;
	logic [frsb_pkg::PIX_W-1:0]  dst_s1, src_s1;
	logic [frsb_pkg::WD_W-1:0]   wn_s1, wc_s1, wd_s1;
	frsb_pkg::ctl_t              ctl_s1;
	logic                        rdy_s2;

	assign pix_in.ready = !v_s1 || rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pix_in.ready) begin
			v_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_in.ready && pix_in.valid) begin
			dst_s1 <= pix_in.dest_pixel;
			src_s1 <= pix_in.source_pixel;
			wn_s1  <= wn_c;
			wc_s1  <= wd_c - wn_c;
			wd_s1  <= wd_c;
			ctl_s1 <= ctl_c;
		end
	end

	// Stage 2: numerators, rounded dividend and aligned divisor
	frsb_pkg::div_t              div_c;
	logic [frsb_pkg::PROD_W-1:0] pd_c [CN];
	logic [frsb_pkg::PROD_W-1:0] ps_c [CN];

	always_comb begin
		div_c     = '0;
		div_c.ctl = ctl_s1;
		div_c.dvs = frsb_pkg::DVS_W'({wd_s1, 1'b0}) << (CW - 1);
		for (int c = 0; c < CN; c++) begin
			pd_c[c] = frsb_pkg::PROD_W'(dst_s1[c*CW +: CW]) * frsb_pkg::PROD_W'(wc_s1);
			ps_c[c] = frsb_pkg::PROD_W'(src_s1[c*CW +: CW]) * frsb_pkg::PROD_W'(wn_s1);
			div_c.rem[c] = frsb_pkg::REM_W'({pd_c[c] + ps_c[c], 1'b0})
				+ frsb_pkg::REM_W'(wd_s1);
		end
	end

	logic           v_s2;
	frsb_pkg::div_t div_s2;
	logic           step_v   [CW+1];
	logic           step_rdy [CW+1];
	frsb_pkg::div_t step_d   [CW+1];

	assign rdy_s2 = !v_s2 || step_rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			div_s2 <= div_c;
		end
	end

	assign step_v[0] = v_s2;
	assign step_d[0] = div_s2;

	// Stages 3 to 10: one quotient bit per stage, most significant first
	for (genvar k = 0; k < CW; k++) begin : g_div
		frsb_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (step_v[k]),
			.in_ready  (step_rdy[k]),
			.in_data   (step_d[k]),
			.out_valid (step_v[k+1]),
			.out_ready (step_rdy[k+1]),
			.out_data  (step_d[k+1])
		);
	end

	// Stage 11: output register
	logic                       v_s11;
	logic [frsb_pkg::PIX_W-1:0] pix_s11;
	logic [frsb_pkg::PIX_W-1:0] pix_c;

	assign step_rdy[CW] = !v_s11 || pix_out.ready;

	always_comb begin
		pix_c = step_d[CW].ctl.byp;
		if (step_d[CW].ctl.mix) begin
			for (int c = 0; c < CN; c++) begin
				pix_c[c*CW +: CW] = step_d[CW].quo[c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else if (step_rdy[CW]) begin
			v_s11 <= step_v[CW];
		end
	end

	always_ff @(posedge clk) begin
		if (step_rdy[CW] && step_v[CW]) begin
			pix_s11 <= pix_c;
		end
	end

	assign pix_out.valid         = v_s11;
	assign pix_out.blended_pixel = pix_s11;

endmodule

[rtl/frsb_checker.sv]
// Port-level checks for feathered_rgba_seam_blend and the bind that attaches them.
// Depends on assert_macros.svh and frsb_pkg.
`include "assert_macros.svh"

module frsb_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [frsb_pkg::PIX_W-1:0]  out_pixel,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [frsb_pkg::ADDR_W-1:0] paddr,
	input logic [frsb_pkg::CFG_W-1:0]  pwdata,
	input logic [frsb_pkg::CFG_W-1:0]  prdata
);

	`ASSERT_PROP(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "output beat dropped while stalled")
	`ASSERT_PROP(a_out_stable, clk, arst_n, out_valid && !out_ready |=> $stable(out_pixel), "stalled output beat changed")
	`ASSERT_PROP(a_in_free, clk, arst_n, !out_valid || out_ready |-> in_ready, "input blocked with a free output")
	`ASSERT_PROP(a_cfg_readback, clk, arst_n, psel && penable && pwrite |=> paddr != $past(paddr) || prdata == frsb_pkg::CFG_W'($past(pwdata[frsb_pkg::SPAN_W-1:0])), "register readback mismatch")

endmodule

bind feathered_rgba_seam_blend frsb_checker u_frsb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (pix_in.ready),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.out_pixel (pix_out.blended_pixel),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata)
);

[test/feathered_rgba_seam_blend_test.sv]
// Self-checking bench for feathered_rgba_seam_blend: drives pixel beats and APB writes,
// predicts each blended pixel and compares it in arrival order, with and without random stalls.
// Depends on frsb_pkg, frsb_if.sv and the block's RTL.
`timescale 1ns / 100ps

module feathered_rgba_seam_blend_test;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 14;
	localparam int MAX_REPORTS = 10;
	localparam logic [frsb_pkg::PIX_W-1:0] DST_A = 32'hC8_3C_A0_FF;
	localparam logic [frsb_pkg::PIX_W-1:0] SRC_A = 32'h50_E0_14_01;

	typedef struct packed {
		logic                        axis;
		logic                        blend_enable;
		logic [frsb_pkg::SPAN_W-1:0] position;
		logic [frsb_pkg::PIX_W-1:0]  dest_pixel;
		logic [frsb_pkg::PIX_W-1:0]  source_pixel;
	} pixel_beat_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [frsb_pkg::ADDR_W-1:0] paddr;
	logic [frsb_pkg::CFG_W-1:0] pwdata;
	logic [frsb_pkg::CFG_W-1:0] prdata;
	logic pready;

	frsb_in_if  pixel_in ();
	frsb_out_if pixel_out ();

	feathered_rgba_seam_blend u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pixel_in),
		.pix_out (pixel_out),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	logic [frsb_pkg::SPAN_W-1:0] span_reg [4];
	logic [frsb_pkg::PIX_W-1:0] pending_pixels [$];
	logic [frsb_pkg::PIX_W-1:0] want_pixel;
	int src_idle_pct;
	int sink_idle_pct;
	int beats_sent;
	int pixels_checked;
	int settings_used;
	int mismatch_count;
	int cycle_count;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic int span_limit(int v);
		return (v > frsb_pkg::MAX_SPAN - 1) ? frsb_pkg::MAX_SPAN - 1 : v;
	endfunction

	function automatic logic [frsb_pkg::PIX_W-1:0] feather_blend(pixel_beat_t b);
		int pos;
		int ov;
		int fe;
		int n;
		int wn;
		int wd;
		int d;
		int s;
		longint num;
		longint c;
		logic [frsb_pkg::PIX_W-1:0] res;
		pos = span_limit(int'(b.position));
		ov = span_limit(int'(b.axis ? span_reg[frsb_pkg::REG_V_OVERLAP]
			: span_reg[frsb_pkg::REG_H_OVERLAP]));
		fe = span_limit(int'(b.axis ? span_reg[frsb_pkg::REG_V_FEATHER]
			: span_reg[frsb_pkg::REG_H_FEATHER]));
		if (!b.blend_enable) begin
			wn = 1;
			wd = 1;
		end else if (fe == 0) begin
			wd = 1;
			wn = (2 * pos < ov) ? 0 : 1;
		end else begin
			n = 2 * pos - ov + fe;
			wd = 2 * fe;
			wn = (n <= 0) ? 0 : ((n >= wd) ? wd : n);
		end
		if (b.source_pixel[31:24] == 8'd0) begin
			res = b.dest_pixel;
		end else if (b.dest_pixel[31:24] == 8'd0 || wn == wd) begin
			res = b.source_pixel;
		end else if (wn == 0) begin
			res = b.dest_pixel;
		end else begin
			for (int ch = 0; ch < frsb_pkg::CH_N; ch++) begin
				d = int'(b.dest_pixel[ch*frsb_pkg::CH_W +: frsb_pkg::CH_W]);
				s = int'(b.source_pixel[ch*frsb_pkg::CH_W +: frsb_pkg::CH_W]);
				num = longint'(d) * (wd - wn) + longint'(s) * wn;
				c = (2 * num + wd) / (2 * wd);
				if (c > 255)
					c = 255;
				res[ch*frsb_pkg::CH_W +: frsb_pkg::CH_W] = c[frsb_pkg::CH_W-1:0];
			end
		end
		return res;
	endfunction

	task automatic note_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("MISMATCH at %0t: %s", $realtime, what);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				pending_pixels.size());
			$display("feathered_rgba_seam_blend_test: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		pixel_out.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && pixel_out.valid && pixel_out.ready) begin
			if (pending_pixels.size() == 0) begin
				note_mismatch($sformatf("blended_pixel %h with no beat pending",
					pixel_out.blended_pixel));
			end else begin
				want_pixel = pending_pixels.pop_front();
				pixels_checked++;
				if (pixel_out.blended_pixel !== want_pixel)
					note_mismatch($sformatf("blended_pixel expected %h, got %h",
						want_pixel, pixel_out.blended_pixel));
			end
		end
	end

	task automatic send_pixel(input logic ax, input logic en,
		input logic [frsb_pkg::SPAN_W-1:0] pos,
		input logic [frsb_pkg::PIX_W-1:0] dst, input logic [frsb_pkg::PIX_W-1:0] src);
		pixel_beat_t b;
		b = '{axis: ax, blend_enable: en, position: pos, dest_pixel: dst, source_pixel: src};
		while ($urandom_range(0, 99) < src_idle_pct) begin
			pixel_in.valid <= 1'b0;
			@(posedge clk);
		end
		pixel_in.valid <= 1'b1;
		pixel_in.axis <= b.axis;
		pixel_in.blend_enable <= b.blend_enable;
		pixel_in.position <= b.position;
		pixel_in.dest_pixel <= b.dest_pixel;
		pixel_in.source_pixel <= b.source_pixel;
		@(posedge clk);
		while (!pixel_in.ready)
			@(posedge clk);
		pending_pixels = {pending_pixels, feather_blend(b)};
		beats_sent++;
	endtask

	task automatic wait_drained();
		pixel_in.valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input frsb_pkg::reg_idx_t idx,
		input logic [frsb_pkg::SPAN_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {20'($urandom()), value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		span_reg[idx] = value;
		@(posedge clk);
	endtask

	task automatic set_spans(input logic [frsb_pkg::SPAN_W-1:0] h_ov,
		input logic [frsb_pkg::SPAN_W-1:0] h_fe,
		input logic [frsb_pkg::SPAN_W-1:0] v_ov, input logic [frsb_pkg::SPAN_W-1:0] v_fe);
		wait_drained();
		write_reg(frsb_pkg::REG_H_OVERLAP, h_ov);
		write_reg(frsb_pkg::REG_H_FEATHER, h_fe);
		write_reg(frsb_pkg::REG_V_OVERLAP, v_ov);
		write_reg(frsb_pkg::REG_V_FEATHER, v_fe);
		settings_used++;
	endtask

	function automatic logic [frsb_pkg::SPAN_W-1:0] pick_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return '0;
		if (r < 22)
			return '1;
		if (r < 32)
			return frsb_pkg::SPAN_W'($urandom());
		return frsb_pkg::SPAN_W'($urandom_range(1, 48));
	endfunction

	task automatic test_reset_defaults();
		send_pixel(1'b0, 1'b1, 12'd0, DST_A, SRC_A);
		send_pixel(1'b1, 1'b1, 12'd0, DST_A, 32'h00FF_FFFF);
		send_pixel(1'b0, 1'b0, 12'd4095, DST_A, SRC_A);
	endtask

	task automatic test_hard_cut();
		set_spans(12'd10, 12'd0, 12'd4095, 12'd0);
		send_pixel(1'b0, 1'b1, 12'd4, DST_A, SRC_A);
		send_pixel(1'b0, 1'b1, 12'd5, DST_A, SRC_A);
		send_pixel(1'b1, 1'b1, 12'd2047, DST_A, SRC_A);
		send_pixel(1'b1, 1'b1, 12'd4095, DST_A, SRC_A);
	endtask

	task automatic test_feather_ramp();
		set_spans(12'd16, 12'd8, 12'd2, 12'd10);
		send_pixel(1'b0, 1'b1, 12'd3, DST_A, SRC_A);
		send_pixel(1'b0, 1'b1, 12'd4, DST_A, SRC_A);
		send_pixel(1'b0, 1'b1, 12'd5, DST_A, SRC_A);
		send_pixel(1'b0, 1'b1, 12'd8, DST_A, SRC_A);
		send_pixel(1'b0, 1'b1, 12'd11, DST_A, SRC_A);
		send_pixel(1'b0, 1'b1, 12'd12, DST_A, SRC_A);
		send_pixel(1'b0, 1'b1, 12'd4095, DST_A, SRC_A);
		send_pixel(1'b0, 1'b1, 12'd8, 32'h00FF_FFFF, SRC_A);
		send_pixel(1'b0, 1'b1, 12'd8, DST_A, 32'h00FF_FFFF);
		send_pixel(1'b0, 1'b0, 12'd0, DST_A, SRC_A);
		send_pixel(1'b0, 1'b1, 12'd8, 32'hFFFF_FFFF, 32'h0100_0000);
		send_pixel(1'b1, 1'b1, 12'd0, DST_A, SRC_A);
		send_pixel(1'b1, 1'b1, 12'd6, DST_A, SRC_A);
	endtask

	task automatic test_rounding_halves();
		set_spans(12'd0, 12'd1, 12'd4095, 12'd4095);
		send_pixel(1'b0, 1'b1, 12'd0, 32'hFF00_0000, 32'h0101_0101);
		send_pixel(1'b1, 1'b1, 12'd2047, 32'hFFFF_FFFF, 32'h01FF_0080);
		send_pixel(1'b1, 1'b1, 12'd0, DST_A, SRC_A);
	endtask

	task automatic test_random_pixels(input int per_block, input int blocks);
		int ov;
		int fe;
		int lo;
		int hi;
		logic ax;
		logic [frsb_pkg::SPAN_W-1:0] pos;
		logic [frsb_pkg::PIX_W-1:0] dst;
		logic [frsb_pkg::PIX_W-1:0] src;
		for (int blk = 0; blk < blocks; blk++) begin
			set_spans(pick_span(), pick_span(), pick_span(), pick_span());
			for (int k = 0; k < per_block; k++) begin
				ax = 1'($urandom_range(0, 1));
				ov = int'(ax ? span_reg[frsb_pkg::REG_V_OVERLAP]
					: span_reg[frsb_pkg::REG_H_OVERLAP]);
				fe = int'(ax ? span_reg[frsb_pkg::REG_V_FEATHER]
					: span_reg[frsb_pkg::REG_H_FEATHER]);
				lo = (ov - fe) / 2 - 2;
				hi = (ov + fe) / 2 + 2;
				if (lo < 0)
					lo = 0;
				if (hi > frsb_pkg::MAX_SPAN - 1)
					hi = frsb_pkg::MAX_SPAN - 1;
				if ($urandom_range(0, 99) < 65)
					pos = frsb_pkg::SPAN_W'($urandom_range(hi, lo));
				else
					pos = frsb_pkg::SPAN_W'($urandom());
				dst = $urandom();
				src = $urandom();
				if ($urandom_range(0, 99) < 8)
					dst[31:24] = 8'd0;
				if ($urandom_range(0, 99) < 8)
					src[31:24] = 8'd0;
				send_pixel(ax, ($urandom_range(0, 99) < 88), pos, dst, src);
				if ($urandom_range(0, 99) < 3)
					wait_drained();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pixel_in.valid = 1'b0;
		pixel_in.axis = 1'b0;
		pixel_in.blend_enable = 1'b0;
		pixel_in.position = '0;
		pixel_in.dest_pixel = '0;
		pixel_in.source_pixel = '0;
		pixel_out.ready = 1'b0;
		for (int i = 0; i < 4; i++)
			span_reg[i] = '0;
		src_idle_pct = 36;
		sink_idle_pct = 60;
		beats_sent = 0;
		pixels_checked = 0;
		settings_used = 1;
		mismatch_count = 0;
		cycle_count = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_hard_cut();
		test_feather_ramp();
		test_rounding_halves();
		test_random_pixels(40, 4);
		src_idle_pct = 60;
		sink_idle_pct = 36;
		test_random_pixels(40, 4);
		src_idle_pct = 0;
		sink_idle_pct = 0;
		test_random_pixels(40, 4);

		wait_drained();
		$display("Covered %0d pixel beats and %0d checked results over %0d span settings,",
			beats_sent, pixels_checked, settings_used);
		$display("with sender-heavy, receiver-heavy and stall-free traffic; %0d mismatches.",
			mismatch_count);
		if (mismatch_count == 0)
			$display("feathered_rgba_seam_blend_test: done, clean");
		else
			$display("feathered_rgba_seam_blend_test: done, errors");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/frsb_pkg.sv
rtl/frsb_if.sv
rtl/frsb_div_step.sv
rtl/feathered_rgba_seam_blend.sv
rtl/frsb_checker.sv
test/feathered_rgba_seam_blend_test.sv
